>>> hdl/fpa_pkg.sv
// Shared constants and types for the fixed-point ALU.
// No dependencies; imported by fpa_div and fixed_point_alu.
`timescale 1ns / 1ps
`default_nettype none

package fpa_pkg;

   localparam int FRAC_BITS = 8;
   localparam int WORD_W    = 32;
   localparam int QUOT_W    = WORD_W + FRAC_BITS;
   localparam int DIV_LAT   = QUOT_W + 2;
   localparam int QUICK_LAT = 2;
   localparam int DLY_DEPTH = DIV_LAT - QUICK_LAT + 1;

   typedef enum logic [3:0] {
      OP_ADD     = 4'd0,
      OP_SUB     = 4'd1,
      OP_MUL     = 4'd2,
      OP_DIV     = 4'd3,
      OP_GT      = 4'd4,
      OP_LT      = 4'd5,
      OP_GE      = 4'd6,
      OP_LE      = 4'd7,
      OP_EQ      = 4'd8,
      OP_NE      = 4'd9,
      OP_MIN     = 4'd10,
      OP_MAX     = 4'd11,
      OP_INC     = 4'd12,
      OP_DEC     = 4'd13,
      OP_TOINT   = 4'd14,
      OP_FROMINT = 4'd15
   } op_type;

   typedef struct packed {
      logic                       valid;
      logic                       is_div;
      logic signed [WORD_W-1:0]   value;
      logic                       cmp;
   } quick_type;

endpackage

`default_nettype wire

>>> hdl/fpa_div.sv
// Pipelined signed fixed-point divider, one quotient bit per stage.
// Depends on fpa_pkg for widths and latency.
`timescale 1ns / 1ps
`default_nettype none

module fpa_div
   import fpa_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   input  wire logic signed [WORD_W-1:0]  in_a,
   input  wire logic signed [WORD_W-1:0]  in_b,
   output logic                           out_valid,
   output logic signed [WORD_W-1:0]       out_quot,
   output logic                           out_dz
);

   logic [QUOT_W:0]       vld_ff;
   logic                  out_valid_ff;
   logic [WORD_W-1:0]     rem_ff [QUOT_W+1];
   logic [QUOT_W-1:0]     num_ff [QUOT_W+1];
   logic [WORD_W-1:0]     dsr_ff [QUOT_W+1];
   logic [QUOT_W:0]       neg_ff;
   logic [QUOT_W:0]       dz_ff;
   logic [WORD_W-1:0]     rem_in [QUOT_W];
   logic [QUOT_W-1:0]     num_in [QUOT_W];
   logic signed [WORD_W-1:0] quot_ff;
   logic                  dz_out_ff;
   logic [WORD_W-1:0]     mag_a;
   logic [WORD_W-1:0]     mag_b;
   logic [WORD_W-1:0]     q_low;

   assign mag_a = in_a[WORD_W-1] ? (~in_a + 1'b1) : in_a;
   assign mag_b = in_b[WORD_W-1] ? (~in_b + 1'b1) : in_b;
   assign q_low = num_ff[QUOT_W][WORD_W-1:0];

   always_comb begin
      logic [WORD_W:0] trial;
      logic            ge;
      for (int k = 0; k < QUOT_W; k++) begin
         trial     = {rem_ff[k], num_ff[k][QUOT_W-1]};
         ge        = (trial >= {1'b0, dsr_ff[k]});
         rem_in[k] = ge ? WORD_W'(trial - {1'b0, dsr_ff[k]}) : trial[WORD_W-1:0];
         num_in[k] = {num_ff[k][QUOT_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= {vld_ff[QUOT_W-1:0], in_valid};
         out_valid_ff <= vld_ff[QUOT_W];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= '0;
      num_ff[0] <= QUOT_W'(mag_a) << FRAC_BITS;
      dsr_ff[0] <= mag_b;
      neg_ff[0] <= in_a[WORD_W-1] ^ in_b[WORD_W-1];
      dz_ff[0]  <= (in_b == '0);
      for (int k = 0; k < QUOT_W; k++) begin
         rem_ff[k+1] <= rem_in[k];
         num_ff[k+1] <= num_in[k];
         dsr_ff[k+1] <= dsr_ff[k];
         neg_ff[k+1] <= neg_ff[k];
         dz_ff[k+1]  <= dz_ff[k];
      end
      dz_out_ff <= dz_ff[QUOT_W];
      if (dz_ff[QUOT_W]) begin
         quot_ff <= '0;
      end else begin
         quot_ff <= neg_ff[QUOT_W] ? (~q_low + 1'b1) : q_low;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_quot  = quot_ff;
   assign out_dz    = dz_out_ff;

endmodule

`default_nettype wire

>>> hdl/fixed_point_alu.sv
// Top level of the signed fixed-point ALU.
// Depends on fpa_pkg and fpa_div.
//
//  channel | ports                                   | handshake
//  request | req_op, req_operand_a, req_operand_b    | start, busy
//  result  | rsp_result_value, rsp_compare_true,     | rsp_valid strobe
//          | rsp_divide_by_zero                      |
//
// One request enters per cycle; busy is always low.
// Every request takes as long as a divide, which is set by the
// divider, which resolves one quotient bit per stage; other operations are
// delayed to match the divider so results leave in request order.
// Synchronous reset clears all valid bits; no state survives a request.
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_alu
   import fpa_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [3:0]                req_op,
   input  wire logic signed [WORD_W-1:0]  req_operand_a,
   input  wire logic signed [WORD_W-1:0]  req_operand_b,
   output logic                           rsp_valid,
   output logic signed [WORD_W-1:0]       rsp_result_value,
   output logic                           rsp_compare_true,
   output logic                           rsp_divide_by_zero
);

   logic                      v0_ff;
   op_type                    op0_ff;
   logic signed [WORD_W-1:0]  a0_ff;
   logic signed [WORD_W-1:0]  b0_ff;

   logic                      v1_ff;
   logic                      mul1_ff;
   logic                      div1_ff;
   logic signed [2*WORD_W-1:0] prod1_ff;
   logic signed [WORD_W-1:0]  val1_ff;
   logic                      cmp1_ff;

   quick_type                 dly_ff [DLY_DEPTH];
   quick_type                 q2_in;

   logic signed [WORD_W-1:0]  val1_in;
   logic                      cmp1_in;
   logic signed [2*WORD_W-1:0] prod_adj;

   logic                      div_valid;
   logic signed [WORD_W-1:0]  div_quot;
   logic                      div_dz;

   logic                      rsp_valid_ff;
   logic signed [WORD_W-1:0]  rsp_value_ff;
   logic                      rsp_cmp_ff;
   logic                      rsp_dz_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= start;
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      op0_ff <= op_type'(req_op);
      a0_ff  <= req_operand_a;
      b0_ff  <= req_operand_b;
   end

   always_comb begin
      val1_in = '0;
      cmp1_in = 1'b0;
      case (op0_ff)
         OP_ADD:     val1_in = a0_ff + b0_ff;
         OP_SUB:     val1_in = a0_ff - b0_ff;
         OP_GT:      cmp1_in = (a0_ff > b0_ff);
         OP_LT:      cmp1_in = (a0_ff < b0_ff);
         OP_GE:      cmp1_in = (a0_ff >= b0_ff);
         OP_LE:      cmp1_in = (a0_ff <= b0_ff);
         OP_EQ:      cmp1_in = (a0_ff == b0_ff);
         OP_NE:      cmp1_in = (a0_ff != b0_ff);
         OP_MIN:     val1_in = (a0_ff < b0_ff) ? a0_ff : b0_ff;
         OP_MAX:     val1_in = (a0_ff > b0_ff) ? a0_ff : b0_ff;
         OP_INC:     val1_in = a0_ff + 32'sd1;
         OP_DEC:     val1_in = a0_ff - 32'sd1;
         OP_TOINT:   val1_in = a0_ff >>> FRAC_BITS;
         OP_FROMINT: val1_in = a0_ff <<< FRAC_BITS;
         default:    val1_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      mul1_ff  <= (op0_ff == OP_MUL);
      div1_ff  <= (op0_ff == OP_DIV);
      prod1_ff <= 64'(a0_ff) * 64'(b0_ff);
      val1_ff  <= val1_in;
      cmp1_ff  <= cmp1_in;
   end

   // bias negative products so the shift truncates toward zero
   assign prod_adj = prod1_ff[2*WORD_W-1]
                     ? prod1_ff + ((64'sd1 <<< FRAC_BITS) - 64'sd1)
                     : prod1_ff;

   always_comb begin
      q2_in.valid  = v1_ff;
      q2_in.is_div = div1_ff;
      q2_in.value  = mul1_ff ? prod_adj[FRAC_BITS +: WORD_W] : val1_ff;
      q2_in.cmp    = cmp1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DLY_DEPTH; k++) begin
            dly_ff[k].valid <= 1'b0;
         end
      end else begin
         dly_ff[0].valid <= q2_in.valid;
         for (int k = 1; k < DLY_DEPTH; k++) begin
            dly_ff[k].valid <= dly_ff[k-1].valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      dly_ff[0].is_div <= q2_in.is_div;
      dly_ff[0].value  <= q2_in.value;
      dly_ff[0].cmp    <= q2_in.cmp;
      for (int k = 1; k < DLY_DEPTH; k++) begin
         dly_ff[k].is_div <= dly_ff[k-1].is_div;
         dly_ff[k].value  <= dly_ff[k-1].value;
         dly_ff[k].cmp    <= dly_ff[k-1].cmp;
      end
   end

   fpa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v0_ff),
      .in_a      (a0_ff),
      .in_b      (b0_ff),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_dz    (div_dz)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dly_ff[DLY_DEPTH-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (dly_ff[DLY_DEPTH-1].is_div && div_valid) begin
         rsp_value_ff <= div_quot;
         rsp_dz_ff    <= div_dz;
      end else begin
         rsp_value_ff <= dly_ff[DLY_DEPTH-1].value;
         rsp_dz_ff    <= 1'b0;
      end
      rsp_cmp_ff <= dly_ff[DLY_DEPTH-1].cmp;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_value   = rsp_value_ff;
   assign rsp_compare_true   = rsp_cmp_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;

endmodule

`default_nettype wire
